// ----- src/shelf_atlas_allocator_unit_assert.svh -----
// assertion macros used by the shelf atlas allocator checker
`ifndef SHELF_ATLAS_ALLOCATOR_UNIT_ASSERT_SVH
`define SHELF_ATLAS_ALLOCATOR_UNIT_ASSERT_SVH

// plain property checked every cycle outside reset
`define SALA_ASSERT(name, clk, rst, prop) \
  name: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("shelf atlas allocator assertion failed");

// implication: when ante holds, cons must hold in the same cycle
`define SALA_ASSERT_IMPL(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("shelf atlas allocator assertion failed");

`endif

// ----- src/sala_pkg.sv -----
// types and constants of the shelf atlas allocator
`timescale 1ns / 1ps

package sala_pkg;

  localparam int ATLAS_SIZE = 1024;
  // pen and row height range over 0..ATLAS_SIZE
  localparam int POS_W = $clog2(ATLAS_SIZE + 1);
  // sums of a pen value and a glyph size plus one
  localparam int SUM_W = POS_W + 1;

  localparam int DIM_W = 10;
  localparam int COORD_W = 10;
  localparam int BOT_W = 11;

  localparam logic [SUM_W-1:0] SIZE_S = SUM_W'(ATLAS_SIZE);
  localparam logic [POS_W-1:0] SIZE_P = POS_W'(ATLAS_SIZE);

  typedef enum logic {
    OP_PLACE = 1'b0,
    OP_FLUSH = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_PLACED  = 2'd0,
    ST_SKIPPED = 2'd1,
    ST_FULL    = 2'd2,
    ST_FLUSH   = 2'd3
  } status_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [DIM_W-1:0]   glyph_width;
    logic [DIM_W-1:0]   glyph_height;
  } req_t;

  typedef struct packed {
    status_t            status;
    logic [COORD_W-1:0] atlas_x;
    logic [COORD_W-1:0] atlas_y;
    logic               dirty_valid;
    logic [COORD_W-1:0] dirty_top;
    logic [BOT_W-1:0]   dirty_bottom;
  } rsp_t;

endpackage

// ----- src/sala_req_if.sv -----
// request channel: valid, ready and one request word
`timescale 1ns / 1ps

interface sala_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [9:0]  glyph_width;
  logic [9:0]  glyph_height;

  modport source (output valid, opcode, glyph_width, glyph_height, input ready);
  modport sink (input valid, opcode, glyph_width, glyph_height, output ready);
endinterface

// ----- src/sala_rsp_if.sv -----
// result channel: valid, ready and one result word
`timescale 1ns / 1ps

interface sala_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [9:0]  atlas_x;
  logic [9:0]  atlas_y;
  logic        dirty_valid;
  logic [9:0]  dirty_top;
  logic [10:0] dirty_bottom;

  modport source (output valid, status, atlas_x, atlas_y, dirty_valid, dirty_top,
                  dirty_bottom, input ready);
  modport sink (input valid, status, atlas_x, atlas_y, dirty_valid, dirty_top,
                dirty_bottom, output ready);
endinterface

// ----- src/shelf_atlas_allocator_unit.sv -----
// Shelf allocator for a square glyph atlas. Place and flush requests arrive
// on req; every request gives exactly one result word on rsp, in order. The
// unit takes one request per clock while rsp is ready: a request is latched
// in an input register, and once the result register is free or being
// emptied the placement logic reads the pen and dirty band state, updates it
// and loads the result register, which offers the result word on rsp.
// Throughput is one word per cycle as long as rsp is ready; the result
// register keeps its word while rsp stalls and the input register still
// takes one more request.
`timescale 1ns / 1ps

module shelf_atlas_allocator_unit (
  input logic clk,
  input logic rst,
  sala_req_if.sink   req,
  sala_rsp_if.source rsp
);
  import sala_pkg::*;

  logic stg_valid;
  req_t stg;
  logic out_valid;
  rsp_t out;
  rsp_t res;
  logic step;

  // the stage fires when the result register is free or being emptied
  assign step      = stg_valid && (!out_valid || rsp.ready);
  assign req.ready = !stg_valid || step;

  always_ff @(posedge clk) begin
    if (rst) begin
      stg_valid <= 1'b0;
    end else if (req.ready) begin
      stg_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req.valid && req.ready) begin
      stg.opcode       <= opcode_t'(req.opcode);
      stg.glyph_width  <= req.glyph_width;
      stg.glyph_height <= req.glyph_height;
    end
  end

  sala_core u_core (
    .clk  (clk),
    .rst  (rst),
    .step (step),
    .req  (stg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out <= res;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.status       = out.status;
  assign rsp.atlas_x      = out.atlas_x;
  assign rsp.atlas_y      = out.atlas_y;
  assign rsp.dirty_valid  = out.dirty_valid;
  assign rsp.dirty_top    = out.dirty_top;
  assign rsp.dirty_bottom = out.dirty_bottom;

endmodule

// ----- src/sala_core.sv -----
// pen, row and dirty band state with the single-pass placement logic
`timescale 1ns / 1ps

module sala_core (
  input  logic          clk,
  input  logic          rst,
  input  logic          step,
  input  sala_pkg::req_t req,
  output sala_pkg::rsp_t res
);
  import sala_pkg::*;

  logic [POS_W-1:0]   pen_x, pen_x_next;
  logic [POS_W-1:0]   pen_y, pen_y_next;
  logic [POS_W-1:0]   row_height, row_height_next;
  logic               dirty_flag, dirty_flag_next;
  logic [COORD_W-1:0] dirty_first_row, dirty_first_row_next;
  logic [BOT_W-1:0]   dirty_end_row, dirty_end_row_next;

  logic [SUM_W-1:0]   sum_x;
  logic [SUM_W-1:0]   ny;
  logic [SUM_W-1:0]   sum_y;
  logic [SUM_W-1:0]   w_plus;
  logic               wrap;
  logic               full;
  logic               empty;
  logic [POS_W-1:0]   px, py, rh;
  logic [POS_W-1:0]   bot;

  always_comb begin
    sum_x = SUM_W'(pen_x) + SUM_W'(req.glyph_width) + SUM_W'(1);
    wrap  = sum_x > SIZE_S;
    ny    = SUM_W'(pen_y) + SUM_W'(row_height) + SUM_W'(1);
    px    = wrap ? '0 : pen_x;
    py    = wrap ? ((ny > SIZE_S) ? SIZE_P : ny[POS_W-1:0]) : pen_y;
    rh    = wrap ? '0 : row_height;
    sum_y = SUM_W'(py) + SUM_W'(req.glyph_height) + SUM_W'(1);
    w_plus = SUM_W'(req.glyph_width) + SUM_W'(1);
    full  = (sum_y > SIZE_S) || (w_plus > SIZE_S);
    empty = (req.glyph_width == '0) || (req.glyph_height == '0);
    // cannot overflow: only used when the glyph fits below the atlas edge
    bot   = py + POS_W'(req.glyph_height);
  end

  always_comb begin
    pen_x_next           = pen_x;
    pen_y_next           = pen_y;
    row_height_next      = row_height;
    dirty_flag_next      = dirty_flag;
    dirty_first_row_next = dirty_first_row;
    dirty_end_row_next   = dirty_end_row;
    res                  = '0;
    unique case (req.opcode)
      OP_FLUSH: begin
        res.status       = ST_FLUSH;
        res.dirty_valid  = dirty_flag;
        res.dirty_top    = dirty_flag ? dirty_first_row : '0;
        res.dirty_bottom = dirty_flag ? dirty_end_row : '0;
        dirty_flag_next  = 1'b0;
      end
      OP_PLACE: begin
        if (empty) begin
          res.status = ST_SKIPPED;
        end else begin
          // the row move sticks even when the glyph is then refused
          pen_x_next      = px;
          pen_y_next      = py;
          row_height_next = rh;
          if (full) begin
            res.status = ST_FULL;
          end else begin
            res.status  = ST_PLACED;
            res.atlas_x = px[COORD_W-1:0];
            res.atlas_y = py[COORD_W-1:0];
            if (!dirty_flag || (py[COORD_W-1:0] < dirty_first_row)) begin
              dirty_first_row_next = py[COORD_W-1:0];
            end
            if (!dirty_flag || (BOT_W'(bot) > dirty_end_row)) begin
              dirty_end_row_next = BOT_W'(bot);
            end
            dirty_flag_next = 1'b1;
            pen_x_next      = px + POS_W'(req.glyph_width) + POS_W'(1);
            if (POS_W'(req.glyph_height) > rh) begin
              row_height_next = POS_W'(req.glyph_height);
            end
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pen_x           <= '0;
      pen_y           <= '0;
      row_height      <= '0;
      dirty_flag      <= 1'b0;
      dirty_first_row <= '0;
      dirty_end_row   <= '0;
    end else if (step) begin
      pen_x           <= pen_x_next;
      pen_y           <= pen_y_next;
      row_height      <= row_height_next;
      dirty_flag      <= dirty_flag_next;
      dirty_first_row <= dirty_first_row_next;
      dirty_end_row   <= dirty_end_row_next;
    end
  end

endmodule

// ----- src/sala_checker.sv -----
// port-level checks of the shelf atlas allocator and their bind
`timescale 1ns / 1ps

`include "shelf_atlas_allocator_unit_assert.svh"

module sala_prop_checker (
  input logic        clk,
  input logic        rst,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [9:0]  atlas_x,
  input logic [9:0]  atlas_y,
  input logic        dirty_valid,
  input logic [9:0]  dirty_top,
  input logic [10:0] dirty_bottom
);
  import sala_pkg::*;

  logic is_flush;
  logic is_placed;
  logic stalled_prev;
  logic band_clear;
  logic band_sane;

  assign is_flush   = status == ST_FLUSH;
  assign is_placed  = status == ST_PLACED;
  assign band_clear = (dirty_top == 10'd0) && (dirty_bottom == 11'd0);
  assign band_sane  = dirty_valid ? ({1'b0, dirty_top} < dirty_bottom) : band_clear;

  always_ff @(posedge clk) begin
    if (rst) begin
      stalled_prev <= 1'b0;
    end else begin
      stalled_prev <= rsp_valid && !rsp_ready;
    end
  end

  // a waiting word stays offered
  `SALA_ASSERT_IMPL(a_hold_valid, clk, rst, stalled_prev, rsp_valid)

  // only a flush answer carries the dirty band
  `SALA_ASSERT_IMPL(a_band_on_flush, clk, rst, rsp_valid && !is_flush, !dirty_valid && band_clear)

  // coordinates only on a placed glyph
  `SALA_ASSERT_IMPL(a_xy_on_place, clk, rst, rsp_valid && !is_placed, atlas_x == 10'd0 && atlas_y == 10'd0)

  // a reported band is never empty, a clean flush reports nothing
  `SALA_ASSERT(a_band_order, clk, rst, !rsp_valid || !is_flush || band_sane)

endmodule

bind shelf_atlas_allocator_unit sala_prop_checker u_sala_prop_checker (
  .clk          (clk),
  .rst          (rst),
  .rsp_valid    (rsp.valid),
  .rsp_ready    (rsp.ready),
  .status       (rsp.status),
  .atlas_x      (rsp.atlas_x),
  .atlas_y      (rsp.atlas_y),
  .dirty_valid  (rsp.dirty_valid),
  .dirty_top    (rsp.dirty_top),
  .dirty_bottom (rsp.dirty_bottom)
);
